// ===== design/gps_text_sentence_position_parser_assert.svh =====
// Assertion macros shared by the parser's RTL files.
// Each macro expands to one labeled concurrent assertion that is
// disabled while reset is asserted.
`ifndef GPS_TEXT_SENTENCE_POSITION_PARSER_ASSERT_SVH
`define GPS_TEXT_SENTENCE_POSITION_PARSER_ASSERT_SVH

// The condition holds at every clock edge.
`define GTSP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("gtsp: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define GTSP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gtsp: same-cycle implication violated");

// The consequent holds in the cycle after the antecedent.
`define GTSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gtsp: next-cycle implication violated");

`endif

// ===== design/gtsp_pkg.sv =====
// ----------------------------------------------------------------------------
// gtsp_pkg
// Shared constants, character codes and the frame record type of the GPS
// sentence position parser.
// ----------------------------------------------------------------------------
package gtsp_pkg;

    // Frame geometry.
    localparam int FRAME_LENGTH = 57;
    localparam int POS_W        = $clog2(FRAME_LENGTH);

    // Character codes.
    localparam logic [7:0] CHAR_AT         = 8'h40;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_NINE       = 8'h39;

    // Fixed byte positions inside a frame.
    localparam logic [POS_W-1:0] LAT_HEMI_POS = POS_W'(13);
    localparam logic [POS_W-1:0] NO_FIX_POS   = POS_W'(14);
    localparam logic [POS_W-1:0] LON_HEMI_POS = POS_W'(21);

    // Digit slots: latitude 14..20, longitude 22..29, accuracy 31..33.
    localparam int NUM_DIGITS = 18;
    localparam logic [POS_W-1:0] DIGIT_POS [NUM_DIGITS] = '{
        POS_W'(14), POS_W'(15), POS_W'(16), POS_W'(17), POS_W'(18), POS_W'(19),
        POS_W'(20), POS_W'(22), POS_W'(23), POS_W'(24), POS_W'(25), POS_W'(26),
        POS_W'(27), POS_W'(28), POS_W'(29), POS_W'(31), POS_W'(32), POS_W'(33)
    };

    // Slot numbers of the first digit of each decoded group.
    localparam int LAT_DEG_SLOT  = 0;
    localparam int LAT_MIN_SLOT  = 2;
    localparam int LAT_FRAC_SLOT = 4;
    localparam int LON_DEG_SLOT  = 7;
    localparam int LON_MIN_SLOT  = 10;
    localparam int LON_FRAC_SLOT = 12;
    localparam int ACC_SLOT      = 15;

    // Output widths.
    localparam int LAT_W = 23;
    localparam int LON_W = 26;
    localparam int ACC_W = 10;

    // One completed frame, already classified by the front end.
    typedef struct packed {
        logic [7:0]                  lat_hemi;
        logic [7:0]                  lon_hemi;
        logic                        no_fix;
        logic                        digit_err;
        logic [NUM_DIGITS-1:0][3:0]  digits;
    } frame_rec_t;

endpackage

// ===== design/gtsp_fifo.sv =====
// ----------------------------------------------------------------------------
// gtsp_fifo
// Two-entry queue of completed frame records between the front end and the
// decoder, so that each side can stall on its own.
// ----------------------------------------------------------------------------
`include "gps_text_sentence_position_parser_assert.svh"

module gtsp_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  gtsp_pkg::frame_rec_t push_data,
    output logic                 push_ready,
    input  logic                 pop,
    output logic                 pop_valid,
    output gtsp_pkg::frame_rec_t pop_data
);

    gtsp_pkg::frame_rec_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    // Status toward both sides.
    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `GTSP_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= 2'd2)
    `GTSP_ASSERT_IMPLIES(a_no_overflow, aclk, aresetn, push, count_reg != 2'd2)
    `GTSP_ASSERT_IMPLIES(a_no_underflow, aclk, aresetn, pop, count_reg != 2'd0)

endmodule

// ===== design/gtsp_front.sv =====
// ----------------------------------------------------------------------------
// gtsp_front
// Accepts one received byte per cycle while the queue has room, tracks the
// write position inside the frame and classifies the bytes that matter:
// hemisphere characters, the invalid-fix marker and the digit values with
// their error flag. A completed frame is pushed as one record into the queue.
// ----------------------------------------------------------------------------
`include "gps_text_sentence_position_parser_assert.svh"

module gtsp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_rx_byte,
    output logic                 push,
    output gtsp_pkg::frame_rec_t push_data,
    input  logic                 push_ready
);

    logic [gtsp_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [gtsp_pkg::POS_W-1:0] pos_eff;
    logic [7:0] lat_hemi_reg, lat_hemi_next;
    logic [7:0] lon_hemi_reg, lon_hemi_next;
    logic       no_fix_reg, no_fix_next;
    logic       err_reg, err_next;
    logic [3:0] digit_reg  [gtsp_pkg::NUM_DIGITS];
    logic [3:0] digit_next [gtsp_pkg::NUM_DIGITS];
    logic       accept;
    logic       last;
    logic       is_digit;
    logic       digit_hit;
    logic [3:0] byte_val;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    // Position of this byte, with restart on a start character.
    always_comb begin
        pos_eff = ((s_rx_byte == gtsp_pkg::CHAR_AT) && (pos_reg != '0)) ? '0 : pos_reg;
        last    = (pos_eff == gtsp_pkg::POS_W'(gtsp_pkg::FRAME_LENGTH - 1));
        pos_next = last ? '0 : pos_eff + gtsp_pkg::POS_W'(1);
    end

    // Byte classification and capture into the field registers.
    always_comb begin
        is_digit  = (s_rx_byte >= gtsp_pkg::CHAR_ZERO) && (s_rx_byte <= gtsp_pkg::CHAR_NINE);
        byte_val  = is_digit ? s_rx_byte[3:0] : 4'd0;
        digit_hit = 1'b0;
        for (int k = 0; k < gtsp_pkg::NUM_DIGITS; k++) begin
            if (pos_eff == gtsp_pkg::DIGIT_POS[k]) begin
                digit_next[k] = byte_val;
                digit_hit     = 1'b1;
            end else begin
                digit_next[k] = digit_reg[k];
            end
        end
        lat_hemi_next = (pos_eff == gtsp_pkg::LAT_HEMI_POS) ? s_rx_byte : lat_hemi_reg;
        lon_hemi_next = (pos_eff == gtsp_pkg::LON_HEMI_POS) ? s_rx_byte : lon_hemi_reg;
        no_fix_next   = (pos_eff == gtsp_pkg::NO_FIX_POS)
                      ? (s_rx_byte == gtsp_pkg::CHAR_UNDERSCORE) : no_fix_reg;
        err_next      = ((pos_eff == '0) ? 1'b0 : err_reg) | (digit_hit && !is_digit);
    end

    // The record includes the byte that completes the frame.
    always_comb begin
        push_data.lat_hemi  = lat_hemi_next;
        push_data.lon_hemi  = lon_hemi_next;
        push_data.no_fix    = no_fix_next;
        push_data.digit_err = err_next;
        for (int k = 0; k < gtsp_pkg::NUM_DIGITS; k++) begin
            push_data.digits[k] = digit_next[k];
        end
        push = accept && last;
    end

    // Write position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (accept) begin
            pos_reg <= pos_next;
        end
    end

    // Captured fields of the frame in progress.
    always_ff @(posedge aclk) begin
        if (accept) begin
            lat_hemi_reg <= lat_hemi_next;
            lon_hemi_reg <= lon_hemi_next;
            no_fix_reg   <= no_fix_next;
            err_reg      <= err_next;
            for (int k = 0; k < gtsp_pkg::NUM_DIGITS; k++) begin
                digit_reg[k] <= digit_next[k];
            end
        end
    end

    `GTSP_ASSERT_ALWAYS(a_pos_in_frame, aclk, aresetn,
        pos_reg < gtsp_pkg::POS_W'(gtsp_pkg::FRAME_LENGTH))
    `GTSP_ASSERT_NEXT(a_wrap_after_last, aclk, aresetn, push, pos_reg == '0)

endmodule

// ===== design/gtsp_decode.sv =====
// ----------------------------------------------------------------------------
// gtsp_decode
// Two-stage decoder: the first stage turns digit groups into decimal values,
// the second scales degrees and minutes into thousandths of a minute and
// holds the result register toward the output channel.
// ----------------------------------------------------------------------------
module gtsp_decode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rec_valid,
    input  gtsp_pkg::frame_rec_t          rec,
    output logic                          rec_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_fix_valid,
    output logic [7:0]                    m_lat_hemisphere,
    output logic [gtsp_pkg::LAT_W-1:0]    m_latitude_milliminutes,
    output logic [7:0]                    m_lon_hemisphere,
    output logic [gtsp_pkg::LON_W-1:0]    m_longitude_milliminutes,
    output logic [gtsp_pkg::ACC_W-1:0]    m_accuracy,
    output logic                          m_digit_error
);

    // Two-digit decimal value.
    function automatic logic [6:0] dec2(input logic [3:0] d1, input logic [3:0] d0);
        return 7'(7'(d1) * 7'd10) + 7'(d0);
    endfunction

    // Three-digit decimal value.
    function automatic logic [9:0] dec3(input logic [3:0] d2, input logic [3:0] d1,
                                        input logic [3:0] d0);
        return 10'(10'(d2) * 10'd100) + 10'(10'(d1) * 10'd10) + 10'(d0);
    endfunction

    logic       s1_valid_reg, s1_valid_next;
    logic       out_valid_reg, out_valid_next;
    logic       adv_out;
    logic       s1_load;

    logic [7:0] s1_lat_hemi_reg, s1_lon_hemi_reg;
    logic       s1_no_fix_reg, s1_err_reg;
    logic [6:0] s1_lat_deg_reg, s1_lat_min_reg, s1_lon_min_reg;
    logic [9:0] s1_lat_frac_reg, s1_lon_deg_reg, s1_lon_frac_reg, s1_acc_reg;

    logic [gtsp_pkg::LAT_W-1:0] lat_sum;
    logic [gtsp_pkg::LON_W-1:0] lon_sum;

    // Pipeline flow: the result register frees up when taken, stage one
    // moves on whenever the result register can take it.
    always_comb begin
        adv_out        = !out_valid_reg || m_ready;
        s1_load        = !s1_valid_reg || adv_out;
        rec_pop        = rec_valid && s1_load;
        s1_valid_next  = s1_load ? rec_valid : s1_valid_reg;
        out_valid_next = adv_out ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage one: digit groups to decimal values.
    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_lat_hemi_reg <= rec.lat_hemi;
            s1_lon_hemi_reg <= rec.lon_hemi;
            s1_no_fix_reg   <= rec.no_fix;
            s1_err_reg      <= rec.digit_err;
            s1_lat_deg_reg  <= dec2(rec.digits[gtsp_pkg::LAT_DEG_SLOT],
                                    rec.digits[gtsp_pkg::LAT_DEG_SLOT + 1]);
            s1_lat_min_reg  <= dec2(rec.digits[gtsp_pkg::LAT_MIN_SLOT],
                                    rec.digits[gtsp_pkg::LAT_MIN_SLOT + 1]);
            s1_lat_frac_reg <= dec3(rec.digits[gtsp_pkg::LAT_FRAC_SLOT],
                                    rec.digits[gtsp_pkg::LAT_FRAC_SLOT + 1],
                                    rec.digits[gtsp_pkg::LAT_FRAC_SLOT + 2]);
            s1_lon_deg_reg  <= dec3(rec.digits[gtsp_pkg::LON_DEG_SLOT],
                                    rec.digits[gtsp_pkg::LON_DEG_SLOT + 1],
                                    rec.digits[gtsp_pkg::LON_DEG_SLOT + 2]);
            s1_lon_min_reg  <= dec2(rec.digits[gtsp_pkg::LON_MIN_SLOT],
                                    rec.digits[gtsp_pkg::LON_MIN_SLOT + 1]);
            s1_lon_frac_reg <= dec3(rec.digits[gtsp_pkg::LON_FRAC_SLOT],
                                    rec.digits[gtsp_pkg::LON_FRAC_SLOT + 1],
                                    rec.digits[gtsp_pkg::LON_FRAC_SLOT + 2]);
            s1_acc_reg      <= dec3(rec.digits[gtsp_pkg::ACC_SLOT],
                                    rec.digits[gtsp_pkg::ACC_SLOT + 1],
                                    rec.digits[gtsp_pkg::ACC_SLOT + 2]);
        end
    end

    // Stage two: scale to thousandths of a minute.
    always_comb begin
        lat_sum = gtsp_pkg::LAT_W'(gtsp_pkg::LAT_W'(s1_lat_deg_reg) * 23'd60000)
                + gtsp_pkg::LAT_W'(gtsp_pkg::LAT_W'(s1_lat_min_reg) * 23'd1000)
                + gtsp_pkg::LAT_W'(s1_lat_frac_reg);
        lon_sum = gtsp_pkg::LON_W'(gtsp_pkg::LON_W'(s1_lon_deg_reg) * 26'd60000)
                + gtsp_pkg::LON_W'(gtsp_pkg::LON_W'(s1_lon_min_reg) * 26'd1000)
                + gtsp_pkg::LON_W'(s1_lon_frac_reg);
    end

    // Result register; an invalid fix zeroes every decoded value.
    always_ff @(posedge aclk) begin
        if (adv_out) begin
            m_fix_valid              <= !s1_no_fix_reg;
            m_lat_hemisphere         <= s1_lat_hemi_reg;
            m_lon_hemisphere         <= s1_lon_hemi_reg;
            m_latitude_milliminutes  <= s1_no_fix_reg ? '0 : lat_sum;
            m_longitude_milliminutes <= s1_no_fix_reg ? '0 : lon_sum;
            m_accuracy               <= s1_no_fix_reg ? '0 : s1_acc_reg;
            m_digit_error            <= !s1_no_fix_reg && s1_err_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// ===== design/gps_text_sentence_position_parser.sv =====
// ----------------------------------------------------------------------------
// gps_text_sentence_position_parser
// Parses fixed-length position sentences, one received byte per transaction,
// and returns one decoded position result for every completed frame.
//
//   Channel  | Ports                    | Transaction
//   ---------+--------------------------+------------------------------------
//   input    | s_valid, s_ready, s_*    | one received character
//   result   | m_valid, m_ready, m_*    | one decoded frame
//
// One byte is taken every cycle while the queue has room; the front end
// holds the frame position and classifies each byte in the cycle it arrives.
// A result passes from the frame's last byte through the queue entry, the
// stage-one register and the result register.
// Reset is synchronous and clears the position and all valid flags; no
// clearing pass is needed.
// The input stalls only while both queue entries hold undelivered frames.
// ----------------------------------------------------------------------------
module gps_text_sentence_position_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_fix_valid,
    output logic [7:0]                    m_lat_hemisphere,
    output logic [gtsp_pkg::LAT_W-1:0]    m_latitude_milliminutes,
    output logic [7:0]                    m_lon_hemisphere,
    output logic [gtsp_pkg::LON_W-1:0]    m_longitude_milliminutes,
    output logic [gtsp_pkg::ACC_W-1:0]    m_accuracy,
    output logic                          m_digit_error
);

    logic                 push;
    logic                 push_ready;
    gtsp_pkg::frame_rec_t push_data;
    logic                 pop;
    logic                 pop_valid;
    gtsp_pkg::frame_rec_t pop_data;

    // Byte intake and classification.
    gtsp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    // Queue of completed frames.
    gtsp_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    // Decimal decode and result register.
    gtsp_decode u_decode (
        .aclk                     (aclk),
        .aresetn                  (aresetn),
        .rec_valid                (pop_valid),
        .rec                      (pop_data),
        .rec_pop                  (pop),
        .m_valid                  (m_valid),
        .m_ready                  (m_ready),
        .m_fix_valid              (m_fix_valid),
        .m_lat_hemisphere         (m_lat_hemisphere),
        .m_latitude_milliminutes  (m_latitude_milliminutes),
        .m_lon_hemisphere         (m_lon_hemisphere),
        .m_longitude_milliminutes (m_longitude_milliminutes),
        .m_accuracy               (m_accuracy),
        .m_digit_error            (m_digit_error)
    );

endmodule
